// ===== sv/ihex_pkg.sv =====
// Shared types, constants and a helper function for the Intel HEX record parser.
package ihex_pkg;

    localparam int RECORD_COUNT_BITS_DEF = 24;
    localparam int RECORD_NUMBER_W = 24;
    localparam int COUNT_EXT_W = 32;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_EOF   = 2'd2;

    localparam logic [7:0] TYPE_DATA     = 8'd0;
    localparam logic [7:0] TYPE_EOF      = 8'd1;
    localparam logic [7:0] TYPE_SEGMENT  = 8'd2;
    localparam logic [7:0] TYPE_EXTENDED = 8'd4;
    localparam logic [7:0] TYPE_LAST_KNOWN = 8'd5;

    localparam logic [8:0] POS_LEN    = 9'd0;
    localparam logic [8:0] POS_OFF_HI = 9'd1;
    localparam logic [8:0] POS_OFF_LO = 9'd2;
    localparam logic [8:0] POS_TYPE   = 9'd3;
    localparam logic [8:0] POS_DATA0  = 9'd4;
    localparam logic [8:0] POS_DATA1  = 9'd5;

    typedef struct packed {
        logic [1:0]                 result_kind;
        logic [31:0]                address;
        logic [7:0]                 data;
        logic                       checksum_error;
        logic [7:0]                 computed_sum;
        logic                       unknown_type;
        logic                       truncated;
        logic                       missing_end_record;
        logic [RECORD_NUMBER_W-1:0] record_number;
        logic [7:0]                 record_kind;
    } result_t;

    // Nibble value without validation; non-digits may exceed 15.
    function automatic logic [4:0] nibble_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            v = {1'b0, c[3:0]};
        end
        else
        begin
            v = {1'b0, c[3:0]} + 5'd9;
        end
        return v;
    endfunction

endpackage

// ===== sv/ihex_core.sv =====
// Record decode state and per-character step logic of the Intel HEX parser.
module ihex_core #(
    parameter int RECORD_COUNT_BITS = ihex_pkg::RECORD_COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             mode,
    input  logic [7:0]       text_char,
    output logic             res_valid,
    output ihex_pkg::result_t res
);

    localparam logic [1:0] PH_LINE_START = 2'd0;
    localparam logic [1:0] PH_SKIP       = 2'd1;
    localparam logic [1:0] PH_RECORD     = 2'd2;
    localparam int COUNT_EXT_W_L = ihex_pkg::COUNT_EXT_W;

    logic [1:0]  phase_reg, phase_next;
    logic        lo_pend_reg, lo_pend_next;
    logic [3:0]  hi_nib_reg, hi_nib_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] off_reg, off_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] word_reg, word_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] seg_reg, seg_next;
    logic [15:0] ext_reg, ext_next;
    logic [31:0] base_reg, base_next;
    logic        end_seen_reg, end_seen_next;
    logic [RECORD_COUNT_BITS-1:0] cnt_reg, cnt_next;

    logic [4:0]             nib;
    logic [7:0]             byte_val;
    logic [7:0]             computed;
    logic [COUNT_EXT_W_L-1:0] cnt_ext;

    assign nib      = ihex_pkg::nibble_value(text_char);
    assign byte_val = {hi_nib_reg, 4'b0000} + {3'b000, nib};
    assign computed = 8'd0 - sum_reg;
    assign cnt_ext  = COUNT_EXT_W_L'(cnt_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        lo_pend_next  = lo_pend_reg;
        hi_nib_next   = hi_nib_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        off_next      = off_reg;
        type_next     = type_reg;
        word_next     = word_reg;
        sum_next      = sum_reg;
        seg_next      = seg_reg;
        ext_next      = ext_reg;
        base_next     = base_reg;
        end_seen_next = end_seen_reg;
        cnt_next      = cnt_reg;

        res_valid = 1'b0;
        res = '0;
        res.record_number = cnt_ext[ihex_pkg::RECORD_NUMBER_W-1:0];

        if (step)
        begin
            priority if (mode)
            begin
                res_valid = 1'b1;
                res.result_kind = ihex_pkg::KIND_EOF;
                res.truncated = (phase_reg == PH_RECORD);
                res.missing_end_record = !end_seen_reg;
                phase_next    = PH_LINE_START;
                lo_pend_next  = 1'b0;
                hi_nib_next   = '0;
                pos_next      = '0;
                len_next      = '0;
                off_next      = '0;
                type_next     = '0;
                word_next     = '0;
                sum_next      = '0;
                seg_next      = '0;
                ext_next      = '0;
                base_next     = '0;
                end_seen_next = 1'b0;
                cnt_next      = '0;
            end
            else if (phase_reg == PH_LINE_START)
            begin
                if (text_char == ihex_pkg::CHAR_COLON)
                begin
                    lo_pend_next = 1'b0;
                    hi_nib_next  = '0;
                    pos_next     = '0;
                    len_next     = '0;
                    off_next     = '0;
                    type_next    = '0;
                    word_next    = '0;
                    sum_next     = '0;
                    if (cnt_reg != '1)
                    begin
                        cnt_next = cnt_reg + RECORD_COUNT_BITS'(1);
                    end
                    phase_next = PH_RECORD;
                end
                else if (text_char != ihex_pkg::CHAR_NEWLINE)
                begin
                    phase_next = PH_SKIP;
                end
            end
            else if (phase_reg != PH_RECORD)
            begin
                if (text_char == ihex_pkg::CHAR_NEWLINE)
                begin
                    phase_next = PH_LINE_START;
                end
            end
            else if (text_char == ihex_pkg::CHAR_NEWLINE)
            begin
                res_valid = 1'b1;
                res.result_kind  = ihex_pkg::KIND_DONE;
                res.computed_sum = computed;
                res.unknown_type = (pos_reg > ihex_pkg::POS_TYPE) &&
                                   (type_reg > ihex_pkg::TYPE_LAST_KNOWN);
                res.truncated    = 1'b1;
                res.record_kind  = type_reg;
                phase_next = PH_LINE_START;
            end
            else if (!lo_pend_reg)
            begin
                hi_nib_next  = nib[3:0];
                lo_pend_next = 1'b1;
            end
            else
            begin
                lo_pend_next = 1'b0;
                if (pos_reg == ({1'b0, len_reg} + ihex_pkg::POS_DATA0))
                begin
                    res_valid = 1'b1;
                    res.result_kind    = ihex_pkg::KIND_DONE;
                    res.checksum_error = (computed != byte_val);
                    res.computed_sum   = computed;
                    res.unknown_type   = (type_reg > ihex_pkg::TYPE_LAST_KNOWN);
                    res.record_kind    = type_reg;
                    if (type_reg == ihex_pkg::TYPE_EOF)
                    begin
                        end_seen_next = 1'b1;
                    end
                    else if (type_reg == ihex_pkg::TYPE_SEGMENT)
                    begin
                        seg_next  = word_reg;
                        base_next = {ext_reg, 16'h0000} + {12'h000, word_reg, 4'h0};
                    end
                    else if (type_reg == ihex_pkg::TYPE_EXTENDED)
                    begin
                        ext_next  = word_reg;
                        base_next = {word_reg, 16'h0000} + {12'h000, seg_reg, 4'h0};
                    end
                    phase_next = PH_SKIP;
                end
                else
                begin
                    sum_next = sum_reg + byte_val;
                    pos_next = pos_reg + 9'd1;
                    priority if (pos_reg == ihex_pkg::POS_LEN)
                    begin
                        len_next = byte_val;
                    end
                    else if (pos_reg == ihex_pkg::POS_OFF_HI)
                    begin
                        off_next = {byte_val, off_reg[7:0]};
                    end
                    else if (pos_reg == ihex_pkg::POS_OFF_LO)
                    begin
                        off_next = {off_reg[15:8], byte_val};
                    end
                    else if (pos_reg == ihex_pkg::POS_TYPE)
                    begin
                        type_next = byte_val;
                    end
                    else
                    begin
                        if (pos_reg == ihex_pkg::POS_DATA0)
                        begin
                            word_next = {byte_val, word_reg[7:0]};
                        end
                        else if (pos_reg == ihex_pkg::POS_DATA1)
                        begin
                            word_next = {word_reg[15:8], byte_val};
                        end
                        if (type_reg == ihex_pkg::TYPE_DATA)
                        begin
                            res_valid = 1'b1;
                            res.result_kind = ihex_pkg::KIND_WRITE;
                            res.address = base_reg + {16'h0000, off_reg} +
                                          {23'd0, pos_reg - ihex_pkg::POS_DATA0};
                            res.data = byte_val;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LINE_START;
            lo_pend_reg  <= 1'b0;
            hi_nib_reg   <= '0;
            pos_reg      <= '0;
            len_reg      <= '0;
            off_reg      <= '0;
            type_reg     <= '0;
            word_reg     <= '0;
            sum_reg      <= '0;
            seg_reg      <= '0;
            ext_reg      <= '0;
            base_reg     <= '0;
            end_seen_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            lo_pend_reg  <= lo_pend_next;
            hi_nib_reg   <= hi_nib_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            off_reg      <= off_next;
            type_reg     <= type_next;
            word_reg     <= word_next;
            sum_reg      <= sum_next;
            seg_reg      <= seg_next;
            ext_reg      <= ext_next;
            base_reg     <= base_next;
            end_seen_reg <= end_seen_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule

// ===== sv/ihex_out_reg.sv =====
// Result register with valid and ready toward the output channel.
module ihex_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              load_valid,
    input  ihex_pkg::result_t load_res,
    input  logic              take,
    output logic              valid,
    output ihex_pkg::result_t res
);

    logic              valid_reg, valid_next;
    ihex_pkg::result_t res_reg, res_next;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (load && load_valid)
        begin
            valid_next = 1'b1;
            res_next   = load_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign valid = valid_reg;
    assign res   = res_reg;

endmodule

// ===== sv/intel_hex_record_parser.sv =====
// Top level of the Intel HEX record parser: character in, data writes and reports out.
//
//   Channel  Handshake           Payload
//   input    in_valid/in_ready   mode, text_char
//   output   out_valid/out_ready result_kind, address, data, checksum_error,
//                                computed_sum, unknown_type, truncated,
//                                missing_end_record, record_number, record_kind
//
// Each character is decoded in the cycle of its transfer and its result, if any,
// appears in the result register in the next cycle; one character per cycle is
// sustained unless stalled: in_ready is low only while a result waits, out_ready low.
// After reset the parser is at the start of a line with all bases and counts clear.
module intel_hex_record_parser #(
    parameter int RECORD_COUNT_BITS = ihex_pkg::RECORD_COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  text_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [31:0] address,
    output logic [7:0]  data,
    output logic        checksum_error,
    output logic [7:0]  computed_sum,
    output logic        unknown_type,
    output logic        truncated,
    output logic        missing_end_record,
    output logic [ihex_pkg::RECORD_NUMBER_W-1:0] record_number,
    output logic [7:0]  record_kind
);

    logic              step;
    logic              step_valid;
    ihex_pkg::result_t step_res;
    ihex_pkg::result_t out_res;

    assign in_ready = !out_valid || out_ready;
    assign step     = in_valid && in_ready;

    ihex_core #(
        .RECORD_COUNT_BITS(RECORD_COUNT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .mode      (mode),
        .text_char (text_char),
        .res_valid (step_valid),
        .res       (step_res)
    );

    ihex_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .load_valid (step_valid),
        .load_res   (step_res),
        .take       (out_ready),
        .valid      (out_valid),
        .res        (out_res)
    );

    assign result_kind        = out_res.result_kind;
    assign address            = out_res.address;
    assign data               = out_res.data;
    assign checksum_error     = out_res.checksum_error;
    assign computed_sum       = out_res.computed_sum;
    assign unknown_type       = out_res.unknown_type;
    assign truncated          = out_res.truncated;
    assign missing_end_record = out_res.missing_end_record;
    assign record_number      = out_res.record_number;
    assign record_kind        = out_res.record_kind;

endmodule
